// ===== rtl/ssdw_pkg.sv =====
// ----------------------------------------------------------------------------
// ssdw_pkg
// Shared types, constants and decode functions for the serial display writer.
// ----------------------------------------------------------------------------
package ssdw_pkg;

  // symbol codes on the bus
  localparam logic [1:0] SYM_START = 2'd0;
  localparam logic [1:0] SYM_BIT   = 2'd1;
  localparam logic [1:0] SYM_ACK   = 2'd2;
  localparam logic [1:0] SYM_STOP  = 2'd3;

  // sequence positions
  localparam int         POS_W           = 7;
  localparam logic [6:0] POS_SPLIT_LAST  = 7'd59;
  localparam logic [6:0] POS_SPLIT_FIRST = 7'd60;
  localparam logic [6:0] POS_SEQ_LAST    = 7'd68;
  localparam logic [6:0] POS_DIGIT_FIRST = 7'd21;

  // command bytes
  localparam logic [7:0] CMD_AUTO_ADDR  = 8'h40;
  localparam logic [7:0] CMD_ADDR_ZERO  = 8'hC0;
  localparam logic [7:0] CMD_DISPLAY_ON = 8'h88;
  localparam logic [7:0] SEG_COLON      = 8'h80;

  // value clamp and binary to decimal conversion
  localparam int                BIN_W     = 14;
  localparam logic signed [15:0] VALUE_MAX = 16'sd9999;
  localparam logic [3:0]        DD_STEPS  = 4'(BIN_W);

  // byte selects inside the sequence
  localparam logic [2:0] SEL_AUTO   = 3'd0;
  localparam logic [2:0] SEL_ADDR   = 3'd1;
  localparam logic [2:0] SEL_DIG0   = 3'd2;
  localparam logic [2:0] SEL_DIG1   = 3'd3;
  localparam logic [2:0] SEL_DIG2   = 3'd4;
  localparam logic [2:0] SEL_DIG3   = 3'd5;
  localparam logic [2:0] SEL_BRIGHT = 3'd6;

  typedef struct packed {
    logic signed [15:0] display_value;
    logic               colon_on;
  } in_item_t;

  typedef struct packed {
    logic [1:0] symbol_kind;
    logic       bit_level;
    logic       last_symbol;
  } out_item_t;

  // one classified request between front and back
  typedef struct packed {
    logic             build;
    logic [BIN_W-1:0] value;
    logic             colon;
    logic [2:0]       bright;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } back_state_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] sel;
    logic [2:0] idx;
  } sym_dec_t;

  // digit to segment pattern
  function automatic logic [7:0] seg_of(input logic [3:0] d);
    logic [7:0] s;
    unique case (d)
      4'd0:    s = 8'h3f;
      4'd1:    s = 8'h06;
      4'd2:    s = 8'h5b;
      4'd3:    s = 8'h4f;
      4'd4:    s = 8'h66;
      4'd5:    s = 8'h6d;
      4'd6:    s = 8'h7d;
      4'd7:    s = 8'h07;
      4'd8:    s = 8'h7f;
      4'd9:    s = 8'h6f;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

  // position in the sequence to symbol kind, byte and bit
  function automatic sym_dec_t sym_decode(input logic [POS_W-1:0] pos);
    sym_dec_t         r;
    logic [POS_W-1:0] base;
    logic [POS_W-1:0] off;
    r = '0;
    priority if (pos < 7'd10) begin
      base  = 7'd1;
      r.sel = SEL_AUTO;
    end else if (pos < 7'd21) begin
      base  = 7'd12;
      r.sel = SEL_ADDR;
    end else if (pos < 7'd30) begin
      base  = 7'd21;
      r.sel = SEL_DIG0;
    end else if (pos < 7'd39) begin
      base  = 7'd30;
      r.sel = SEL_DIG1;
    end else if (pos < 7'd48) begin
      base  = 7'd39;
      r.sel = SEL_DIG2;
    end else if (pos < 7'd57) begin
      base  = 7'd48;
      r.sel = SEL_DIG3;
    end else begin
      base  = 7'd59;
      r.sel = SEL_BRIGHT;
    end
    off   = pos - base;
    r.idx = off[2:0];
    priority if (pos == 7'd0 || pos == 7'd11 || pos == 7'd58) begin
      r.kind = SYM_START;
    end else if (pos == 7'd10 || pos == 7'd57 || pos >= POS_SEQ_LAST) begin
      r.kind = SYM_STOP;
    end else if (off == 7'd8) begin
      r.kind = SYM_ACK;
    end else begin
      r.kind = SYM_BIT;
    end
    return r;
  endfunction

endpackage

// ===== rtl/ssdw_front.sv =====
// ----------------------------------------------------------------------------
// ssdw_front
// Accepts requests, clamps the value, holds brightness and tags each request
// as a new sequence or the tail of the one in flight.
// ----------------------------------------------------------------------------
module ssdw_front import ssdw_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_data,
  input  logic      cfg_we,
  input  logic [2:0] cfg_data,
  input  q_status_t q_status,
  output logic      q_wr_en,
  output q_entry_t  q_wr_data
);

  logic       pending_r, pending_nxt;
  logic [2:0] bright_r, bright_nxt;
  logic       accept;

  assign busy   = q_status.full;
  assign accept = start && !busy;

  // brightness register and sequence half tracking
  always_comb begin
    bright_nxt  = cfg_we ? cfg_data : bright_r;
    pending_nxt = accept ? !pending_r : pending_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bright_r  <= 3'd7;
      pending_r <= 1'b0;
    end else begin
      bright_r  <= bright_nxt;
      pending_r <= pending_nxt;
    end
  end

  // clamp and classify
  always_comb begin
    q_wr_en          = accept;
    q_wr_data.build  = !pending_r;
    q_wr_data.colon  = in_data.colon_on;
    q_wr_data.bright = bright_r;
    priority if (in_data.display_value[15]) begin
      q_wr_data.value = '0;
    end else if (in_data.display_value > VALUE_MAX) begin
      q_wr_data.value = VALUE_MAX[BIN_W-1:0];
    end else begin
      q_wr_data.value = in_data.display_value[BIN_W-1:0];
    end
  end

endmodule

// ===== rtl/ssdw_queue.sv =====
// ----------------------------------------------------------------------------
// ssdw_queue
// Two-entry request queue between the front and the serializer.
// ----------------------------------------------------------------------------
module ssdw_queue import ssdw_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      wr_en,
  input  q_entry_t  wr_data,
  input  logic      rd_en,
  output q_entry_t  rd_data,
  output q_status_t status
);

  q_entry_t   mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_wr, do_rd;

  assign status.full  = (count_r == 2'd2);
  assign status.empty = (count_r == 2'd0);
  assign do_wr        = wr_en && !status.full;
  assign do_rd        = rd_en && !status.empty;
  assign rd_data      = mem_r[rd_ptr_r];

  // pointers and fill count
  always_comb begin
    wr_ptr_nxt = do_wr ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_rd ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(do_wr) - 2'(do_rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ===== rtl/ssdw_back.sv =====
// ----------------------------------------------------------------------------
// ssdw_back
// Symbol serializer: converts the value to decimal digits and, while running,
// emits one bus symbol per cycle, first half or tail of the sequence per request.
// ----------------------------------------------------------------------------
module ssdw_back import ssdw_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  q_status_t q_status,
  input  q_entry_t  q_rd_data,
  output logic      q_rd_en,
  output logic      out_strobe,
  output out_item_t out_data
);

  back_state_t      state_r, state_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [BIN_W-1:0] bin_r, bin_nxt;
  logic [15:0]      bcd_r, bcd_nxt;
  logic [3:0]       dd_cnt_r, dd_cnt_nxt;
  logic             colon_r;
  logic [2:0]       bright_r;
  logic             strobe_r, strobe_nxt;
  out_item_t        out_r, out_nxt;
  logic             at_end;
  logic             load;
  logic [15:0]      bcd_adj;
  sym_dec_t         dec;
  logic [7:0]       cur_byte;

  assign at_end     = (pos_r == POS_SPLIT_LAST) || (pos_r == POS_SEQ_LAST);
  assign out_strobe = strobe_r;
  assign out_data   = out_r;

  // run control and request pop
  always_comb begin
    state_nxt = state_r;
    pos_nxt   = pos_r;
    load      = 1'b0;
    q_rd_en   = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        if (!q_status.empty) begin
          q_rd_en   = 1'b1;
          state_nxt = BK_RUN;
        end
      end
      BK_RUN: begin
        pos_nxt = pos_r + 7'd1;
        if (at_end) begin
          if (!q_status.empty) begin
            q_rd_en = 1'b1;
          end else begin
            state_nxt = BK_IDLE;
          end
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
    if (q_rd_en) begin
      load    = q_rd_data.build;
      pos_nxt = q_rd_data.build ? '0 : POS_SPLIT_FIRST;
    end
  end

  // shift-add-3 decimal conversion, one bit per cycle
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      bcd_adj[i*4 +: 4] = (bcd_r[i*4 +: 4] >= 4'd5) ? bcd_r[i*4 +: 4] + 4'd3
                                                    : bcd_r[i*4 +: 4];
    end
    bin_nxt    = bin_r;
    bcd_nxt    = bcd_r;
    dd_cnt_nxt = dd_cnt_r;
    if (load) begin
      bin_nxt    = q_rd_data.value;
      bcd_nxt    = '0;
      dd_cnt_nxt = DD_STEPS;
    end else if (dd_cnt_r != 4'd0) begin
      bcd_nxt    = {bcd_adj[14:0], bin_r[BIN_W-1]};
      bin_nxt    = {bin_r[BIN_W-2:0], 1'b0};
      dd_cnt_nxt = dd_cnt_r - 4'd1;
    end
  end

  // symbol at the current position
  always_comb begin
    dec = sym_decode(pos_r);
    unique case (dec.sel)
      SEL_AUTO:   cur_byte = CMD_AUTO_ADDR;
      SEL_ADDR:   cur_byte = CMD_ADDR_ZERO;
      SEL_DIG0:   cur_byte = seg_of(bcd_r[15:12]);
      SEL_DIG1:   cur_byte = seg_of(bcd_r[11:8]) | (colon_r ? SEG_COLON : 8'h00);
      SEL_DIG2:   cur_byte = seg_of(bcd_r[7:4]);
      SEL_DIG3:   cur_byte = seg_of(bcd_r[3:0]);
      SEL_BRIGHT: cur_byte = CMD_DISPLAY_ON | {5'd0, bright_r};
      default:    cur_byte = 8'h00;
    endcase
    strobe_nxt          = (state_r == BK_RUN);
    out_nxt.symbol_kind = dec.kind;
    out_nxt.bit_level   = (dec.kind == SYM_BIT) ? cur_byte[dec.idx] : 1'b0;
    out_nxt.last_symbol = (pos_r == POS_SEQ_LAST);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= BK_IDLE;
      dd_cnt_r <= 4'd0;
      strobe_r <= 1'b0;
      pos_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      dd_cnt_r <= dd_cnt_nxt;
      strobe_r <= strobe_nxt;
      pos_r    <= pos_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
    out_r <= out_nxt;
    if (load) begin
      colon_r  <= q_rd_data.colon;
      bright_r <= q_rd_data.bright;
    end
  end

  // digits are ready before the first digit byte goes out
  a_digits_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_RUN && pos_r >= POS_DIGIT_FIRST) |-> dd_cnt_r == 4'd0)
    else $error("digit conversion still running at digit bytes");

  // running position stays inside the sequence
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_RUN) |-> pos_r <= POS_SEQ_LAST)
    else $error("symbol position past end of sequence");

  // final symbol of a sequence is a stop
  a_last_is_stop: assert property (@(posedge clk) disable iff (!rst_n)
    (strobe_r && out_r.last_symbol) |-> out_r.symbol_kind == SYM_STOP)
    else $error("last symbol is not a stop");

  // a pop happens only at the end of a run or from idle
  a_pop_point: assert property (@(posedge clk) disable iff (!rst_n)
    q_rd_en |-> (state_r == BK_IDLE || at_end))
    else $error("request popped in the middle of a run");

endmodule

// ===== rtl/seven_segment_display_serial_writer_unit.sv =====
// ----------------------------------------------------------------------------
// seven_segment_display_serial_writer_unit
// Four-digit display writer: turns a value and colon flag into the three-frame
// two-wire bus symbol sequence, one symbol per cycle while the serializer runs.
// ----------------------------------------------------------------------------
// a request passes the queue and the serializer position and output registers
// throughput: a new-sequence request yields 60 symbols, the following request
//   the remaining 9, one symbol per cycle while the serializer runs (69 per pair)
// a two-entry queue takes requests while the serializer runs; busy = queue full
// reset (synchronous, rst_n low): brightness 7, queue empty, nothing pending
// results are strobed for one cycle and cannot be held off by the receiver
module seven_segment_display_serial_writer_unit import ssdw_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  in_item_t   in_data,
  input  logic       cfg_we,
  input  logic [2:0] cfg_data,
  output logic       out_strobe,
  output out_item_t  out_data
);

  q_status_t q_status;
  logic      q_wr_en;
  q_entry_t  q_wr_data;
  logic      q_rd_en;
  q_entry_t  q_rd_data;

  // request front end
  ssdw_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .q_status  (q_status),
    .q_wr_en   (q_wr_en),
    .q_wr_data (q_wr_data)
  );

  // request queue
  ssdw_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_wr_en),
    .wr_data (q_wr_data),
    .rd_en   (q_rd_en),
    .rd_data (q_rd_data),
    .status  (q_status)
  );

  // symbol serializer
  ssdw_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_status   (q_status),
    .q_rd_data  (q_rd_data),
    .q_rd_en    (q_rd_en),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

endmodule
